### hdl/pd_joint_servo_with_startup_ramp_core_defines.svh
// assertion macros for the pd joint servo core
// used by the rtl files that carry concurrent checks; no other dependencies
`ifndef PD_JOINT_SERVO_WITH_STARTUP_RAMP_CORE_DEFINES_SVH
`define PD_JOINT_SERVO_WITH_STARTUP_RAMP_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PDJS_ASSERT(name, prop, clk, rstn) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("pdjs check failed");
`define PDJS_ASSERT_NEXT(name, ante, cons, clk, rstn) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pdjs check failed");
`else
`define PDJS_ASSERT(name, prop, clk, rstn)
`define PDJS_ASSERT_NEXT(name, ante, cons, clk, rstn)
`endif
`endif

### hdl/pdjs_pkg.sv
// shared types, widths and constants of the pd joint servo core
// no dependencies; every rtl file refers to it by scoped names
package pdjs_pkg;

  localparam int JOINTS      = 32;
  localparam int JOINT_AW    = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int JOINT_IDX_W = 5;
  localparam int POS_W       = 32;
  localparam int GAIN_W      = 24;
  localparam int MASK_W      = 32;
  localparam int INV_W       = 16;
  localparam int STEPS_W     = 16;
  localparam int DRIVE_W     = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // datapath widths
  localparam int DIFF_W   = POS_W + 1;
  localparam int VDIFF_W  = POS_W + 2;
  localparam int MUL_A_W  = VDIFF_W;
  localparam int MUL_B_W  = GAIN_W + 1;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int V_W      = VDIFF_W + INV_W;
  localparam int VLO_W    = 26;
  localparam int VHI_W    = V_W - VLO_W;
  localparam int KLO_W    = VLO_W + GAIN_W;
  localparam int KHI_W    = VHI_W + GAIN_W;
  localparam int KDV_W    = V_W + GAIN_W + 1;
  localparam int P_W      = DIFF_W + GAIN_W;
  localparam int SUM_W    = 61;
  localparam int DPROD_W  = DIFF_W + STEPS_W;
  localparam int QUOT_W   = POS_W + 2;
  localparam int SHIFT_FRAC = 8;

  // divider: four quotient bits per cycle
  localparam int DIV_MAG_W  = DPROD_W - 1;
  localparam int DIV_STEP   = 4;
  localparam int DIV_ITER   = 9;
  localparam int DIV_Q_W    = DIV_STEP * DIV_ITER;
  localparam int DIV_TOP_W  = DIV_MAG_W - DIV_Q_W;
  localparam int DIV_CNT_W  = $clog2(DIV_ITER);

  localparam logic signed [KDV_W-1:0] KD_LIMIT = KDV_W'(64'd1 << 58);
  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

  localparam logic [GAIN_W-1:0]  KP_LEG_RST     = GAIN_W'(2048000);
  localparam logic [GAIN_W-1:0]  KP_ARM_RST     = GAIN_W'(768000);
  localparam logic [GAIN_W-1:0]  KD_GAIN_RST    = GAIN_W'(25600);
  localparam logic [MASK_W-1:0]  ARM_MASK_RST   = MASK_W'(66592704);
  localparam logic [INV_W-1:0]   INV_TS_RST     = INV_W'(1000);
  localparam logic [STEPS_W-1:0] RAMP_STEPS_RST = STEPS_W'(1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP_LEG,
    CFG_KP_ARM,
    CFG_KD_GAIN,
    CFG_ARM_MASK,
    CFG_INV_TS,
    CFG_RAMP_STEPS
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0]  kp_leg;
    logic [GAIN_W-1:0]  kp_arm;
    logic [GAIN_W-1:0]  kd_gain;
    logic [MASK_W-1:0]  arm_joint_mask;
    logic [INV_W-1:0]   inv_time_step;
    logic [STEPS_W-1:0] ramp_steps;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] prev_pos;
    logic [POS_W-1:0] prev_ref;
    logic [POS_W-1:0] start_ref;
    logic [POS_W-1:0] start_pos;
  } joint_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_RMUL,
    S_DSTART,
    S_DWAIT,
    S_VMUL,
    S_VLO,
    S_VHI,
    S_PMUL,
    S_SUM,
    S_WB
  } state_e;

endpackage

### hdl/pdjs_if.sv
// valid/ready channel interfaces: joint sample in, drive out, register write
// widths come from pdjs_pkg
interface pdjs_in_if;
  logic                               valid;
  logic                               ready;
  logic [pdjs_pkg::JOINT_IDX_W-1:0]   joint_index;
  logic signed [pdjs_pkg::POS_W-1:0]  measured_pos;
  logic signed [pdjs_pkg::POS_W-1:0]  ref_pos;
  logic                               last_joint;

  modport source (output valid, joint_index, measured_pos, ref_pos, last_joint, input ready);
  modport sink   (input valid, joint_index, measured_pos, ref_pos, last_joint, output ready);
endinterface

interface pdjs_out_if;
  logic                                valid;
  logic                                ready;
  logic [pdjs_pkg::JOINT_IDX_W-1:0]    out_joint;
  logic signed [pdjs_pkg::DRIVE_W-1:0] drive;
  logic                                ramping;

  modport source (output valid, out_joint, drive, ramping, input ready);
  modport sink   (input valid, out_joint, drive, ramping, output ready);
endinterface

interface pdjs_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pdjs_pkg::CFG_IDX_W-1:0]    index;
  logic [pdjs_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/pd_joint_servo_with_startup_ramp_core.sv
// pd joint servo with startup ramp: one drive word per joint sample word.
//
// in_i carries joint samples (index, measured and reference angle, last-of-frame
// mark); out_o returns one word per sample: joint, saturated drive, ramp flag.
// cfg_i writes the gain, mask, rate and ramp registers; it is always ready and the
// user must see that it is written only while no sample is in flight; the block does not enforce it.
// One sample is worked on at a time: the next sample is taken only after the
// previous one has left write-back. In a ramp frame the target needs a divide.
// The work per sample is set by the single shared 34x25 multiplier (four
// products per sample, five in a ramp frame) and the radix-16 divider.
// Per-joint state lives in one memory read at acceptance and written back
// at the end of the sample.
// Reset loads the register defaults and clears the frame counter; the joint
// memory is undefined until the first frame writes it.
// When out_o is stalled the held result stays; the next sample is taken and
// computed, then waits in write-back until the output register is free.
`include "pd_joint_servo_with_startup_ramp_core_defines.svh"
// depends on pdjs_pkg, pdjs_if, pdjs_cfg_regs, pdjs_state_mem, pdjs_div
module pd_joint_servo_with_startup_ramp_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  pdjs_in_if.sink     in_i,
  pdjs_out_if.source  out_o,
  pdjs_cfg_if.sink    cfg_i
);

  pdjs_pkg::cfg_t          cfg;
  pdjs_pkg::state_e        state_q, state_d;
  pdjs_pkg::joint_state_t  mem_rdata, mem_wdata, st_eff, st_q;

  logic                                  in_acc, in_vj;
  logic                                  mem_re, mem_we, div_start, div_done;
  logic                                  out_load, wb_go, in_ready;
  logic [pdjs_pkg::STEPS_W-1:0]          steps_eff, fc_q, fc_d;
  logic                                  first_now, ramp_now;

  logic [pdjs_pkg::JOINT_IDX_W-1:0]      idx_q;
  logic signed [pdjs_pkg::POS_W-1:0]     pos_q, ref_q, target_q, target_d;
  logic                                  first_q, ramp_q, vj_q;
  logic [pdjs_pkg::GAIN_W-1:0]           kp_q;
  logic [pdjs_pkg::STEPS_W-1:0]          f1_q;

  logic signed [pdjs_pkg::POS_W-1:0]     st_prev_pos, st_prev_ref, st_start_ref, st_start_pos;
  logic signed [pdjs_pkg::DIFF_W-1:0]    rdiff, dpos, dref, err;
  logic signed [pdjs_pkg::VDIFF_W-1:0]   vdiff;
  logic signed [pdjs_pkg::MUL_A_W-1:0]   mul_a;
  logic signed [pdjs_pkg::MUL_B_W-1:0]   mul_b;
  logic signed [pdjs_pkg::MUL_P_W-1:0]   mul_p;
  logic signed [pdjs_pkg::DPROD_W-1:0]   dprod_q;
  logic signed [pdjs_pkg::QUOT_W-1:0]    quot;
  logic signed [pdjs_pkg::V_W-1:0]       v_q;
  logic [pdjs_pkg::KLO_W-1:0]            klo_q;
  logic signed [pdjs_pkg::KHI_W-1:0]     khi_q;
  logic signed [pdjs_pkg::P_W-1:0]       p_q;
  logic signed [pdjs_pkg::KDV_W-1:0]     kdv_q, kdv_d;
  logic signed [pdjs_pkg::SUM_W-1:0]     sum_s, shr_s;
  logic signed [pdjs_pkg::DRIVE_W-1:0]   drive_q, drive_d;

  logic                                  out_valid_q;
  logic [pdjs_pkg::JOINT_IDX_W-1:0]      out_joint_q;
  logic signed [pdjs_pkg::DRIVE_W-1:0]   out_drive_q;
  logic                                  out_ramp_q;

  pdjs_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  pdjs_state_mem u_mem (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .raddr_i (pdjs_pkg::JOINT_AW'(in_i.joint_index)),
    .rdata_o (mem_rdata),
    .we_i    (mem_we),
    .waddr_i (pdjs_pkg::JOINT_AW'(idx_q)),
    .wdata_i (mem_wdata)
  );

  pdjs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dprod_q),
    .divisor_i  (steps_eff),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // frame bookkeeping
  assign in_acc    = in_i.valid && in_ready;
  assign in_vj     = 32'(in_i.joint_index) < 32'(pdjs_pkg::JOINTS);
  assign steps_eff = (cfg.ramp_steps == '0) ? pdjs_pkg::STEPS_W'(1) : cfg.ramp_steps;
  assign first_now = (fc_q == '0);
  assign ramp_now  = ((pdjs_pkg::STEPS_W+1)'(fc_q) + 1'b1) < (pdjs_pkg::STEPS_W+1)'(steps_eff);
  assign fc_d      = (in_i.last_joint && (fc_q < steps_eff)) ? fc_q + 1'b1 : fc_q;
  assign mem_re    = in_acc && in_vj;
  assign wb_go     = !out_valid_q || out_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pdjs_pkg::S_IDLE:   if (in_acc) state_d = pdjs_pkg::S_LOAD;
      pdjs_pkg::S_LOAD:   state_d = ramp_q ? pdjs_pkg::S_RMUL : pdjs_pkg::S_VMUL;
      pdjs_pkg::S_RMUL:   state_d = pdjs_pkg::S_DSTART;
      pdjs_pkg::S_DSTART: state_d = pdjs_pkg::S_DWAIT;
      pdjs_pkg::S_DWAIT:  if (div_done) state_d = pdjs_pkg::S_VMUL;
      pdjs_pkg::S_VMUL:   state_d = pdjs_pkg::S_VLO;
      pdjs_pkg::S_VLO:    state_d = pdjs_pkg::S_VHI;
      pdjs_pkg::S_VHI:    state_d = pdjs_pkg::S_PMUL;
      pdjs_pkg::S_PMUL:   state_d = pdjs_pkg::S_SUM;
      pdjs_pkg::S_SUM:    state_d = pdjs_pkg::S_WB;
      pdjs_pkg::S_WB:     if (wb_go) state_d = pdjs_pkg::S_IDLE;
      default:            state_d = pdjs_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = (state_q == pdjs_pkg::S_IDLE);
    div_start = (state_q == pdjs_pkg::S_DSTART);
    out_load  = (state_q == pdjs_pkg::S_WB) && wb_go;
    mem_we    = out_load && vj_q;
  end

  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pdjs_pkg::S_IDLE;
      fc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        fc_q <= fc_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // first frame takes the sample itself as start and previous values
  always_comb begin
    if (first_q) begin
      st_eff.prev_pos  = pos_q;
      st_eff.prev_ref  = ref_q;
      st_eff.start_ref = ref_q;
      st_eff.start_pos = pos_q;
    end else begin
      st_eff = mem_rdata;
    end
  end

  assign st_prev_pos  = $signed(st_q.prev_pos);
  assign st_prev_ref  = $signed(st_q.prev_ref);
  assign st_start_ref = $signed(st_q.start_ref);
  assign st_start_pos = $signed(st_q.start_pos);

  assign rdiff = pdjs_pkg::DIFF_W'(st_start_ref) - pdjs_pkg::DIFF_W'(st_start_pos);
  assign dpos  = pdjs_pkg::DIFF_W'(pos_q) - pdjs_pkg::DIFF_W'(st_prev_pos);
  assign dref  = pdjs_pkg::DIFF_W'(ref_q) - pdjs_pkg::DIFF_W'(st_prev_ref);
  assign err   = pdjs_pkg::DIFF_W'(target_q) - pdjs_pkg::DIFF_W'(pos_q);
  assign vdiff = ramp_q ? -pdjs_pkg::VDIFF_W'(dpos)
                        : pdjs_pkg::VDIFF_W'(dref) - pdjs_pkg::VDIFF_W'(dpos);

  assign target_d = pdjs_pkg::POS_W'(pdjs_pkg::QUOT_W'(st_start_pos) + quot);

  // one shared multiplier, operands picked by step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      pdjs_pkg::S_RMUL: begin
        mul_a = pdjs_pkg::MUL_A_W'(rdiff);
        mul_b = $signed(pdjs_pkg::MUL_B_W'(f1_q));
      end
      pdjs_pkg::S_VMUL: begin
        mul_a = vdiff;
        mul_b = $signed(pdjs_pkg::MUL_B_W'(cfg.inv_time_step));
      end
      pdjs_pkg::S_VLO: begin
        mul_a = $signed(pdjs_pkg::MUL_A_W'(v_q[pdjs_pkg::VLO_W-1:0]));
        mul_b = $signed(pdjs_pkg::MUL_B_W'(cfg.kd_gain));
      end
      pdjs_pkg::S_VHI: begin
        mul_a = pdjs_pkg::MUL_A_W'($signed(v_q[pdjs_pkg::V_W-1:pdjs_pkg::VLO_W]));
        mul_b = $signed(pdjs_pkg::MUL_B_W'(cfg.kd_gain));
      end
      pdjs_pkg::S_PMUL: begin
        mul_a = pdjs_pkg::MUL_A_W'(err);
        mul_b = $signed(pdjs_pkg::MUL_B_W'(kp_q));
      end
      default: ;
    endcase
  end

  assign mul_p = pdjs_pkg::MUL_P_W'(mul_a) * pdjs_pkg::MUL_P_W'(mul_b);

  assign kdv_d = (pdjs_pkg::KDV_W'(khi_q) <<< pdjs_pkg::VLO_W)
               + $signed(pdjs_pkg::KDV_W'(klo_q));

  // an invalid joint drives zero; a kd term beyond the limit saturates by its sign, else floor-shift and clamp
  assign sum_s = pdjs_pkg::SUM_W'(p_q) + pdjs_pkg::SUM_W'(kdv_q);
  assign shr_s = sum_s >>> pdjs_pkg::SHIFT_FRAC;

  always_comb begin
    priority if (!vj_q) begin
      drive_d = '0;
    end else if (kdv_q > pdjs_pkg::KD_LIMIT) begin
      drive_d = pdjs_pkg::DRIVE_MAX;
    end else if (kdv_q < -pdjs_pkg::KD_LIMIT) begin
      drive_d = pdjs_pkg::DRIVE_MIN;
    end else if (shr_s > pdjs_pkg::SUM_W'(pdjs_pkg::DRIVE_MAX)) begin
      drive_d = pdjs_pkg::DRIVE_MAX;
    end else if (shr_s < pdjs_pkg::SUM_W'(pdjs_pkg::DRIVE_MIN)) begin
      drive_d = pdjs_pkg::DRIVE_MIN;
    end else begin
      drive_d = pdjs_pkg::DRIVE_W'(shr_s);
    end
  end

  // ramp frames keep the old tracked reference
  always_comb begin
    mem_wdata.prev_pos  = pos_q;
    mem_wdata.prev_ref  = ramp_q ? st_q.prev_ref : ref_q;
    mem_wdata.start_ref = st_q.start_ref;
    mem_wdata.start_pos = st_q.start_pos;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      idx_q   <= in_i.joint_index;
      pos_q   <= in_i.measured_pos;
      ref_q   <= in_i.ref_pos;
      first_q <= first_now;
      ramp_q  <= ramp_now;
      vj_q    <= in_vj;
      f1_q    <= fc_q + 1'b1;
      kp_q    <= cfg.arm_joint_mask[in_i.joint_index] ? cfg.kp_arm : cfg.kp_leg;
    end
    unique case (state_q)
      pdjs_pkg::S_LOAD: begin
        st_q <= st_eff;
        if (!ramp_q) begin
          target_q <= ref_q;
        end
      end
      pdjs_pkg::S_RMUL:  dprod_q <= mul_p[pdjs_pkg::DPROD_W-1:0];
      pdjs_pkg::S_DWAIT: if (div_done) target_q <= target_d;
      pdjs_pkg::S_VMUL:  v_q     <= mul_p[pdjs_pkg::V_W-1:0];
      pdjs_pkg::S_VLO:   klo_q   <= mul_p[pdjs_pkg::KLO_W-1:0];
      pdjs_pkg::S_VHI:   khi_q   <= mul_p[pdjs_pkg::KHI_W-1:0];
      pdjs_pkg::S_PMUL: begin
        p_q   <= mul_p[pdjs_pkg::P_W-1:0];
        kdv_q <= kdv_d;
      end
      pdjs_pkg::S_SUM:   drive_q <= drive_d;
      default: ;
    endcase
    if (out_load) begin
      out_joint_q <= idx_q;
      out_drive_q <= drive_q;
      out_ramp_q  <= ramp_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_joint = out_joint_q;
  assign out_o.drive     = out_drive_q;
  assign out_o.ramping   = out_ramp_q;

  `PDJS_ASSERT_NEXT(a_accept_reads_state, in_acc, state_q == pdjs_pkg::S_LOAD, clk_i, rst_ni)
  `PDJS_ASSERT(a_no_mem_overlap, !(mem_we && mem_re), clk_i, rst_ni)
  `PDJS_ASSERT(a_div_done_in_wait, div_done |-> (state_q == pdjs_pkg::S_DWAIT), clk_i, rst_ni)
  `PDJS_ASSERT(a_no_result_overwrite, out_load |-> (!out_valid_q || out_o.ready), clk_i, rst_ni)

endmodule

### hdl/pdjs_cfg_regs.sv
// configuration register file of the servo core
// depends on pdjs_pkg and pdjs_cfg_if
module pdjs_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  pdjs_cfg_if.sink          cfg_i,
  output pdjs_pkg::cfg_t    cfg_o
);

  pdjs_pkg::cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp_leg         <= pdjs_pkg::KP_LEG_RST;
      cfg_q.kp_arm         <= pdjs_pkg::KP_ARM_RST;
      cfg_q.kd_gain        <= pdjs_pkg::KD_GAIN_RST;
      cfg_q.arm_joint_mask <= pdjs_pkg::ARM_MASK_RST;
      cfg_q.inv_time_step  <= pdjs_pkg::INV_TS_RST;
      cfg_q.ramp_steps     <= pdjs_pkg::RAMP_STEPS_RST;
    end else if (cfg_i.valid) begin
      // indexes past the list are dropped
      unique case (cfg_i.index)
        pdjs_pkg::CFG_KP_LEG:     cfg_q.kp_leg  <= cfg_i.data[pdjs_pkg::GAIN_W-1:0];
        pdjs_pkg::CFG_KP_ARM:     cfg_q.kp_arm  <= cfg_i.data[pdjs_pkg::GAIN_W-1:0];
        pdjs_pkg::CFG_KD_GAIN:    cfg_q.kd_gain <= cfg_i.data[pdjs_pkg::GAIN_W-1:0];
        pdjs_pkg::CFG_ARM_MASK:
          cfg_q.arm_joint_mask <= cfg_i.data[pdjs_pkg::MASK_W-1:0];
        pdjs_pkg::CFG_INV_TS:
          cfg_q.inv_time_step <= cfg_i.data[pdjs_pkg::INV_W-1:0];
        pdjs_pkg::CFG_RAMP_STEPS:
          cfg_q.ramp_steps <= cfg_i.data[pdjs_pkg::STEPS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### hdl/pdjs_state_mem.sv
// per-joint state memory: previous and startup position and reference
// one write port, one registered read port; depends on pdjs_pkg
module pdjs_state_mem (
  input  logic                            clk_i,
  input  logic                            re_i,
  input  logic [pdjs_pkg::JOINT_AW-1:0]   raddr_i,
  output pdjs_pkg::joint_state_t          rdata_o,
  input  logic                            we_i,
  input  logic [pdjs_pkg::JOINT_AW-1:0]   waddr_i,
  input  pdjs_pkg::joint_state_t          wdata_i
);

  pdjs_pkg::joint_state_t mem_q [pdjs_pkg::JOINTS];
  pdjs_pkg::joint_state_t rdata_q;

  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

endmodule

### hdl/pdjs_div.sv
// signed by unsigned iterative divider for the ramp target, quotient toward zero
// four quotient bits per cycle; depends on pdjs_pkg
module pdjs_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [pdjs_pkg::DPROD_W-1:0] dividend_i,
  input  logic [pdjs_pkg::STEPS_W-1:0]        divisor_i,
  output logic                                done_o,
  output logic signed [pdjs_pkg::QUOT_W-1:0]  quot_o
);

  logic                                busy_q;
  logic                                done_q;
  logic [pdjs_pkg::DIV_CNT_W-1:0]      cnt_q;
  logic                                neg_q;
  logic [pdjs_pkg::STEPS_W-1:0]        rem_q;
  logic [pdjs_pkg::STEPS_W-1:0]        rem_d;
  logic [pdjs_pkg::DIV_Q_W-1:0]        work_q;
  logic [pdjs_pkg::DIV_Q_W-1:0]        work_d;
  logic [pdjs_pkg::DPROD_W-1:0]        mag;
  logic signed [pdjs_pkg::QUOT_W-1:0]  quot_mag;

  assign mag = dividend_i[pdjs_pkg::DPROD_W-1] ? pdjs_pkg::DPROD_W'(-dividend_i)
                                               : pdjs_pkg::DPROD_W'(dividend_i);

  // restoring steps, remainder stays below the divisor
  always_comb begin
    logic [pdjs_pkg::STEPS_W:0] r_ext;
    logic [pdjs_pkg::STEPS_W-1:0] r;
    logic [pdjs_pkg::DIV_Q_W-1:0] w;
    r = rem_q;
    w = work_q;
    for (int k = 0; k < pdjs_pkg::DIV_STEP; k++) begin
      r_ext = {r, w[pdjs_pkg::DIV_Q_W-1]};
      w     = {w[pdjs_pkg::DIV_Q_W-2:0], 1'b0};
      if (r_ext >= {1'b0, divisor_i}) begin
        r    = pdjs_pkg::STEPS_W'(r_ext - {1'b0, divisor_i});
        w[0] = 1'b1;
      end else begin
        r = r_ext[pdjs_pkg::STEPS_W-1:0];
      end
    end
    rem_d  = r;
    work_d = w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == pdjs_pkg::DIV_CNT_W'(pdjs_pkg::DIV_ITER - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q  <= dividend_i[pdjs_pkg::DPROD_W-1];
      rem_q  <= pdjs_pkg::STEPS_W'(mag[pdjs_pkg::DIV_MAG_W-1:pdjs_pkg::DIV_Q_W]);
      work_q <= mag[pdjs_pkg::DIV_Q_W-1:0];
    end else if (busy_q) begin
      rem_q  <= rem_d;
      work_q <= work_d;
    end
  end

  assign quot_mag = $signed(pdjs_pkg::QUOT_W'(work_q));
  assign quot_o   = neg_q ? -quot_mag : quot_mag;
  assign done_o   = done_q;

endmodule
